FILE: rtl/core/acep_pkg.sv
// Shared constants, lane type and arctangent table for the arc centre / end point
// polar converter. No dependencies; used by every module under rtl/core.
`default_nettype none

package acep_pkg;

    localparam int unsigned COORD_W       = 32;
    localparam int unsigned RAD_W         = COORD_W - 1;
    localparam int unsigned ANGLE_W       = 16;
    localparam int unsigned TURN_W        = 32;
    localparam int unsigned GUARD_BITS    = 8;
    localparam int unsigned XW            = 44;
    localparam int unsigned CORDIC_STAGES = 16;

    // 1/K of the CORDIC, Q0.30
    localparam int unsigned GAIN_W        = 30;
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'h26DD3B6A;
    localparam int unsigned GAIN_SPLIT    = 24;

    localparam logic [1:0] OP_END    = 2'd0;
    localparam logic [1:0] OP_CENTRE = 2'd1;
    localparam logic [1:0] OP_POLAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic                       degen;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [XW-1:0]       x;
        logic signed [XW-1:0]       y;
        logic [TURN_W-1:0]          ang;
    } lane_t;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
        logic [TURN_W-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/acep_cell.sv
// One CORDIC micro-rotation cell: registered lane plus valid, rotation or vectoring
// chosen per beat. Depends on acep_pkg.
`default_nettype none

module acep_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire acep_pkg::lane_t up_lane,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output acep_pkg::lane_t     dn_lane
);

    localparam int unsigned XW     = acep_pkg::XW;
    localparam int unsigned TURN_W = acep_pkg::TURN_W;
    localparam logic [TURN_W-1:0] STEP_ANG = acep_pkg::atan_turn(SHIFT);

    logic            valid_reg;
    acep_pkg::lane_t lane_reg;
    acep_pkg::lane_t lane_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic            turn_pos;

    always_comb begin
        xs = up_lane.x >>> SHIFT;
        ys = up_lane.y >>> SHIFT;
        if (up_lane.op == acep_pkg::OP_POLAR) begin
            turn_pos = up_lane.y[XW-1];
        end else begin
            turn_pos = !up_lane.ang[TURN_W-1];
        end
        lane_next = up_lane;
        if (turn_pos) begin
            lane_next.x   = up_lane.x - ys;
            lane_next.y   = up_lane.y + xs;
            lane_next.ang = up_lane.ang - STEP_ANG;
        end else begin
            lane_next.x   = up_lane.x + ys;
            lane_next.y   = up_lane.y - xs;
            lane_next.ang = up_lane.ang + STEP_ANG;
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_lane  = lane_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            lane_reg <= lane_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/acep_prep.sv
// Front end: input register, radius gain multiply and quadrant fold, start vectors.
// Three registered stages. Depends on acep_pkg.
`default_nettype none

module acep_prep (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         operation,
    input  wire logic signed [acep_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [acep_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [acep_pkg::COORD_W-1:0] other_x,
    input  wire logic signed [acep_pkg::COORD_W-1:0] other_y,
    input  wire logic [acep_pkg::RAD_W-1:0]          radius_in,
    input  wire logic [acep_pkg::ANGLE_W-1:0]        bearing_in,
    output logic                                    dn_valid,
    input  wire logic                               dn_ready,
    output acep_pkg::lane_t                         dn_lane
);

    localparam int unsigned CW     = acep_pkg::COORD_W;
    localparam int unsigned DW     = CW + 1;
    localparam int unsigned RAD_W  = acep_pkg::RAD_W;
    localparam int unsigned XW     = acep_pkg::XW;
    localparam int unsigned TURN_W = acep_pkg::TURN_W;
    localparam int unsigned GB     = acep_pkg::GUARD_BITS;
    localparam int unsigned GW     = acep_pkg::GAIN_W;
    localparam int unsigned SPLIT  = acep_pkg::GAIN_SPLIT;
    localparam int unsigned HI_W   = RAD_W - (SPLIT - GB);
    localparam int unsigned HIP_W  = HI_W + GW;
    localparam int unsigned LOP_W  = SPLIT + GW;
    localparam int unsigned SUM_W  = HIP_W + 1;
    localparam int unsigned MAG_W  = SUM_W - (GW - SPLIT);
    localparam logic [LOP_W:0] ROUND_ADD = (LOP_W+1)'(1) << (GW - 1);
    localparam logic [TURN_W-1:0] QUARTER = TURN_W'(1) << (TURN_W - 2);
    localparam logic [TURN_W-1:0] HALF    = TURN_W'(1) << (TURN_W - 1);

    // stage A: captured beat
    logic                     a_valid_reg;
    logic [1:0]               a_op_reg;
    logic signed [CW-1:0]     a_px_reg, a_py_reg;
    logic signed [DW-1:0]     a_dx_reg, a_dy_reg;
    logic [RAD_W-1:0]         a_rad_reg;
    logic [acep_pkg::ANGLE_W-1:0] a_brg_reg;
    logic                     a_ready;

    // stage B: partial products, fold
    logic                     b_valid_reg;
    logic [1:0]               b_op_reg;
    logic signed [CW-1:0]     b_px_reg, b_py_reg;
    logic signed [DW-1:0]     b_dx_reg, b_dy_reg;
    logic                     b_degen_reg;
    logic [HIP_W-1:0]         b_hip_reg;
    logic [LOP_W-1:0]         b_lop_reg;
    logic                     b_neg_reg;
    logic [TURN_W-1:0]        b_ang_reg;
    logic                     b_ready;

    // stage C: start lane
    logic                     c_valid_reg;
    acep_pkg::lane_t          c_lane_reg;
    acep_pkg::lane_t          c_lane_next;
    logic                     c_ready;

    logic [HI_W-1:0]          rad_hi;
    logic [SPLIT-1:0]         rad_lo;
    logic [TURN_W-1:0]        u_ang, u_test;
    logic [LOP_W:0]           lo_sum;
    logic [SUM_W-1:0]         mag_sum;
    logic [MAG_W-1:0]         mag;
    logic signed [XW-1:0]     mag_x, vx, vy;

    assign c_ready = !c_valid_reg || dn_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_op_reg  <= operation;
            a_px_reg  <= point_x;
            a_py_reg  <= point_y;
            a_dx_reg  <= DW'(other_x) - DW'(point_x);
            a_dy_reg  <= DW'(other_y) - DW'(point_y);
            a_rad_reg <= radius_in;
            a_brg_reg <= bearing_in;
        end
    end

    always_comb begin
        rad_hi = a_rad_reg[RAD_W-1:SPLIT-GB];
        rad_lo = {a_rad_reg[SPLIT-GB-1:0], GB'(0)};
        u_ang  = {a_brg_reg, (TURN_W - acep_pkg::ANGLE_W)'(0)};
        u_test = u_ang + QUARTER;
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_op_reg    <= a_op_reg;
            b_px_reg    <= a_px_reg;
            b_py_reg    <= a_py_reg;
            b_dx_reg    <= a_dx_reg;
            b_dy_reg    <= a_dy_reg;
            b_degen_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);
            b_hip_reg   <= HIP_W'(rad_hi) * HIP_W'(acep_pkg::INV_GAIN);
            b_lop_reg   <= LOP_W'(rad_lo) * LOP_W'(acep_pkg::INV_GAIN);
            b_neg_reg   <= u_test[TURN_W-1];
            b_ang_reg   <= u_test[TURN_W-1] ? (u_ang ^ HALF) : u_ang;
        end
    end

    always_comb begin
        lo_sum  = (LOP_W+1)'(b_lop_reg) + ROUND_ADD;
        mag_sum = SUM_W'(b_hip_reg) + SUM_W'(lo_sum[LOP_W:SPLIT]);
        mag     = mag_sum[SUM_W-1:GW-SPLIT];
        mag_x   = signed'(XW'(mag));
        vx      = XW'(b_dx_reg) <<< GB;
        vy      = XW'(b_dy_reg) <<< GB;

        c_lane_next.op    = b_op_reg;
        c_lane_next.degen = b_degen_reg;
        c_lane_next.px    = b_px_reg;
        c_lane_next.py    = b_py_reg;
        if (b_op_reg == acep_pkg::OP_POLAR) begin
            if (b_dx_reg[DW-1]) begin
                c_lane_next.x   = -vx;
                c_lane_next.y   = -vy;
                c_lane_next.ang = HALF;
            end else begin
                c_lane_next.x   = vx;
                c_lane_next.y   = vy;
                c_lane_next.ang = '0;
            end
        end else begin
            c_lane_next.x   = b_neg_reg ? -mag_x : mag_x;
            c_lane_next.y   = '0;
            c_lane_next.ang = b_ang_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            c_lane_reg <= c_lane_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_lane  = c_lane_reg;

endmodule

`default_nettype wire

FILE: rtl/core/acep_post.sv
// Back end: offset rounding, magnitude gain removal, saturation and the output
// register. Two registered stages. Depends on acep_pkg.
`default_nettype none

module acep_post (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        up_valid,
    output logic                             up_ready,
    input  wire acep_pkg::lane_t             up_lane,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [acep_pkg::COORD_W-1:0]     result_x,
    output logic [acep_pkg::COORD_W-1:0]     result_y,
    output logic [acep_pkg::RAD_W-1:0]       result_radius,
    output logic [acep_pkg::ANGLE_W-1:0]     result_bearing,
    output logic                             degenerate
);

    localparam int unsigned CW     = acep_pkg::COORD_W;
    localparam int unsigned RAD_W  = acep_pkg::RAD_W;
    localparam int unsigned AW     = acep_pkg::ANGLE_W;
    localparam int unsigned XW     = acep_pkg::XW;
    localparam int unsigned TURN_W = acep_pkg::TURN_W;
    localparam int unsigned GB     = acep_pkg::GUARD_BITS;
    localparam int unsigned GW     = acep_pkg::GAIN_W;
    localparam int unsigned SPLIT  = acep_pkg::GAIN_SPLIT;
    localparam int unsigned DW     = XW - GB;
    localparam int unsigned SW     = DW + 1;
    localparam int unsigned HI_W   = XW - 2 - SPLIT;
    localparam int unsigned HIP_W  = HI_W + GW;
    localparam int unsigned LOP_W  = SPLIT + GW;
    localparam int unsigned SUM_W  = HIP_W + 1;
    localparam int unsigned RSH    = GW + GB - SPLIT;
    localparam int unsigned R_W    = SUM_W - RSH;
    localparam logic signed [XW-1:0] HALF_LSB = XW'(1) << (GB - 1);
    localparam logic [LOP_W:0] ROUND_ADD = (LOP_W+1)'(1) << (GW + GB - 1);
    localparam logic [TURN_W-1:0] BRG_ROUND = TURN_W'(1) << (TURN_W - AW - 1);
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                 p_valid_reg;
    logic [1:0]           p_op_reg;
    logic                 p_degen_reg;
    logic signed [CW-1:0] p_px_reg, p_py_reg;
    logic signed [DW-1:0] p_dx_reg, p_dy_reg;
    logic [HIP_W-1:0]     p_hip_reg;
    logic [LOP_W-1:0]     p_lop_reg;
    logic [TURN_W-1:0]    p_ang_reg;
    logic                 p_ready;

    logic                 o_valid_reg;
    logic [CW-1:0]        o_rx_reg, o_ry_reg;
    logic [RAD_W-1:0]     o_rr_reg;
    logic [AW-1:0]        o_rb_reg;
    logic                 o_dg_reg;
    logic                 o_ready;

    logic signed [XW-1:0] xr, yr;
    logic signed [DW-1:0] dx, dy;
    logic signed [SW-1:0] sx, sy;
    logic [CW-1:0]        cx, cy;
    logic [LOP_W:0]       lo_sum;
    logic [SUM_W-1:0]     r_sum;
    logic [R_W-1:0]       r_full;
    logic [RAD_W-1:0]     r_sat;
    logic [TURN_W-1:0]    b_sum;

    function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic [CW-1:0] res;
        if (v > SW'(signed'(COORD_MAX))) begin
            res = COORD_MAX;
        end else if (v < signed'(SW'(signed'(COORD_MIN)))) begin
            res = COORD_MIN;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    assign o_ready  = !o_valid_reg || m_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign up_ready = p_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= up_valid;
            end
            if (o_ready) begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_comb begin
        xr = (up_lane.x + HALF_LSB) >>> GB;
        yr = (up_lane.y + HALF_LSB) >>> GB;
        dx = signed'(xr[DW-1:0]);
        dy = signed'(yr[DW-1:0]);
        if (up_lane.op == acep_pkg::OP_CENTRE) begin
            dx = -dx;
            dy = -dy;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && up_valid) begin
            p_op_reg    <= up_lane.op;
            p_degen_reg <= up_lane.degen;
            p_px_reg    <= up_lane.px;
            p_py_reg    <= up_lane.py;
            p_dx_reg    <= dx;
            p_dy_reg    <= dy;
            p_hip_reg   <= HIP_W'(up_lane.x[XW-3:SPLIT]) * HIP_W'(acep_pkg::INV_GAIN);
            p_lop_reg   <= LOP_W'(up_lane.x[SPLIT-1:0]) * LOP_W'(acep_pkg::INV_GAIN);
            p_ang_reg   <= up_lane.ang;
        end
    end

    always_comb begin
        sx     = SW'(p_px_reg) + SW'(p_dx_reg);
        sy     = SW'(p_py_reg) + SW'(p_dy_reg);
        cx     = sat_coord(sx);
        cy     = sat_coord(sy);
        lo_sum = (LOP_W+1)'(p_lop_reg) + ROUND_ADD;
        r_sum  = SUM_W'(p_hip_reg) + SUM_W'(lo_sum[LOP_W:SPLIT]);
        r_full = r_sum[SUM_W-1:RSH];
        r_sat  = (r_full[R_W-1:RAD_W] != '0) ? {RAD_W{1'b1}} : r_full[RAD_W-1:0];
        b_sum  = p_ang_reg + BRG_ROUND;
    end

    always_ff @(posedge aclk) begin
        if (o_ready && p_valid_reg) begin
            o_rx_reg <= '0;
            o_ry_reg <= '0;
            o_rr_reg <= '0;
            o_rb_reg <= '0;
            o_dg_reg <= 1'b0;
            unique case (p_op_reg)
                acep_pkg::OP_END, acep_pkg::OP_CENTRE: begin
                    o_rx_reg <= cx;
                    o_ry_reg <= cy;
                end
                acep_pkg::OP_POLAR: begin
                    if (p_degen_reg) begin
                        o_dg_reg <= 1'b1;
                    end else begin
                        o_rr_reg <= r_sat;
                        o_rb_reg <= b_sum[TURN_W-1:TURN_W-AW];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = o_valid_reg;
    assign result_x       = o_rx_reg;
    assign result_y       = o_ry_reg;
    assign result_radius  = o_rr_reg;
    assign result_bearing = o_rb_reg;
    assign degenerate     = o_dg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/arc_center_end_polar_convert.sv
// Arc centre / end point / radius / bearing converter, top level.
// Instantiates acep_prep, a chain of acep_cell and acep_post; depends on acep_pkg.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata, one conversion per beat:
//   op 0 end point = centre + r*(cos b, sin b), op 1 centre = end - r*(cos b, sin b),
//   op 2 radius and bearing from centre to end (degenerate set if the points coincide).
// Result beats leave on m_tvalid/m_tready/m_tdata, exactly one per input beat, in order.
// Throughput: one beat per clock while m_tready stays high. The pipeline is three
//   front-end stages (input, gain products, start vector), one cell per CORDIC
//   micro-rotation and two back-end stages (rounding/products, output register).
// Each stage holds its own valid bit; a stage loads whenever it is empty or the stage
//   after it moves, so bubbles close up. Ready is combinational along the chain: with
//   every stage full, s_tready follows m_tready in the same cycle.
// Reset (aresetn low, synchronous) empties every stage; no result is pending after it.
`default_nettype none

module arc_center_end_polar_convert #(
    parameter int unsigned CORDIC_STAGES = acep_pkg::CORDIC_STAGES
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // operation[1:0], point_x[33:2], point_y[65:34], other_x[97:66], other_y[129:98],
    // radius_in[160:130], bearing_in[176:161], zero pad[183:177]
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_x[31:0], result_y[63:32], result_radius[94:64], result_bearing[110:95],
    // degenerate[111]
    output logic [111:0]      m_tdata
);

    localparam int unsigned CW = acep_pkg::COORD_W;

    logic [1:0]                       in_op;
    logic signed [CW-1:0]             in_px, in_py, in_ox, in_oy;
    logic [acep_pkg::RAD_W-1:0]       in_rad;
    logic [acep_pkg::ANGLE_W-1:0]     in_brg;

    logic [CW-1:0]                    res_x, res_y;
    logic [acep_pkg::RAD_W-1:0]       res_rad;
    logic [acep_pkg::ANGLE_W-1:0]     res_brg;
    logic                             res_dg;

    acep_pkg::lane_t chain_lane  [0:CORDIC_STAGES];
    logic            chain_valid [0:CORDIC_STAGES];
    logic            chain_ready [0:CORDIC_STAGES];

    assign in_op  = s_tdata[1:0];
    assign in_px  = s_tdata[33:2];
    assign in_py  = s_tdata[65:34];
    assign in_ox  = s_tdata[97:66];
    assign in_oy  = s_tdata[129:98];
    assign in_rad = s_tdata[160:130];
    assign in_brg = s_tdata[176:161];

    acep_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .operation  (in_op),
        .point_x    (in_px),
        .point_y    (in_py),
        .other_x    (in_ox),
        .other_y    (in_oy),
        .radius_in  (in_rad),
        .bearing_in (in_brg),
        .dn_valid   (chain_valid[0]),
        .dn_ready   (chain_ready[0]),
        .dn_lane    (chain_lane[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        acep_cell #(
            .SHIFT (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_lane  (chain_lane[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_lane  (chain_lane[i+1])
        );
    end

    acep_post u_post (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .up_valid       (chain_valid[CORDIC_STAGES]),
        .up_ready       (chain_ready[CORDIC_STAGES]),
        .up_lane        (chain_lane[CORDIC_STAGES]),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .result_x       (res_x),
        .result_y       (res_y),
        .result_radius  (res_rad),
        .result_bearing (res_brg),
        .degenerate     (res_dg)
    );

    assign m_tdata = {res_dg, res_brg, res_rad, res_y, res_x};

endmodule

`default_nettype wire

FILE: dv/tb_arc_center_end_polar_convert.sv
// Self-checking bench for arc_center_end_polar_convert: directed corner beats, then
// random traffic with random gaps and stalls on both streams, each result compared
// field by field with a bit-true CORDIC predictor. Depends on acep_pkg and the RTL.
module tb_arc_center_end_polar_convert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  RESET_CYCLES = 12;
    localparam int unsigned  RANDOM_BEATS = 1050;
    localparam int unsigned  DRAIN_CYCLES = 60;
    localparam int unsigned  CYCLE_LIMIT  = 300000;
    localparam int unsigned  PRINT_CAP    = 100;
    localparam int unsigned  ROT_STAGES   = 16;
    localparam int unsigned  GUARD        = 8;
    localparam longint unsigned GAIN_RECIP = 64'h26DD3B6A;
    localparam logic [1:0]   OP_NONE      = 2'd3;

    localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] C_MIN = 32'sh80000000;
    localparam logic signed [31:0] UNIT  = 32'sh00010000;
    localparam logic [30:0]        R_MAX = 31'h7FFFFFFF;

    // atan(2^-i) in turns, scaled by 2^32
    localparam logic [31:0] ROT_ANGLE [ROT_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    // field order is MSB first, so op lands in the low bits of tdata
    typedef struct packed {
        logic [acep_pkg::ANGLE_W-1:0]        bearing;
        logic [acep_pkg::RAD_W-1:0]          radius;
        logic signed [acep_pkg::COORD_W-1:0] oy;
        logic signed [acep_pkg::COORD_W-1:0] ox;
        logic signed [acep_pkg::COORD_W-1:0] py;
        logic signed [acep_pkg::COORD_W-1:0] px;
        logic [1:0]                          op;
    } conv_req_t;

    typedef struct packed {
        logic                                degen;
        logic [acep_pkg::ANGLE_W-1:0]        bearing;
        logic [acep_pkg::RAD_W-1:0]          radius;
        logic signed [acep_pkg::COORD_W-1:0] ry;
        logic signed [acep_pkg::COORD_W-1:0] rx;
    } conv_res_t;

    function automatic longint unsigned scale_gain(longint unsigned a, int unsigned s);
        longint unsigned hi;
        longint unsigned lo;
        hi = (a >> 24) * GAIN_RECIP;
        lo = (a & 64'hFFFFFF) * GAIN_RECIP + (64'd1 << (s - 1));
        return (hi + (lo >> 24)) >> (s - 24);
    endfunction

    function automatic logic signed [31:0] clamp_coord(longint signed v);
        if (v > 64'sd2147483647) return C_MAX;
        if (v < -64'sd2147483648) return C_MIN;
        return v[31:0];
    endfunction

    class arc_result_board;
        conv_res_t   awaited_results[$];
        int unsigned bad_fields;

        function conv_res_t convert_arc(conv_req_t q);
            conv_res_t       res;
            longint signed   x, y, z, xs, ys, mag, dx, dy;
            longint unsigned r;
            logic [31:0]     u, ang;
            logic [32:0]     rounded;
            int              i;
            res = '0;
            case (q.op)
                acep_pkg::OP_END, acep_pkg::OP_CENTRE: begin
                    mag = longint'(scale_gain({33'd0, q.radius} << GUARD, 30));
                    u = {q.bearing, 16'd0};
                    if (((u + 32'h40000000) & 32'h80000000) != 0) begin
                        mag = -mag;
                        u = u - 32'h80000000;
                    end
                    z = longint'($signed(u));
                    x = mag;
                    y = 0;
                    for (i = 0; i < ROT_STAGES; i++) begin
                        xs = x >>> i;
                        ys = y >>> i;
                        if (z >= 0) begin
                            x -= ys; y += xs; z -= ROT_ANGLE[i];
                        end else begin
                            x += ys; y -= xs; z += ROT_ANGLE[i];
                        end
                    end
                    dx = (x + 128) >>> GUARD;
                    dy = (y + 128) >>> GUARD;
                    if (q.op == acep_pkg::OP_CENTRE) begin
                        dx = -dx;
                        dy = -dy;
                    end
                    res.rx = clamp_coord(longint'($signed(q.px)) + dx);
                    res.ry = clamp_coord(longint'($signed(q.py)) + dy);
                end
                acep_pkg::OP_POLAR: begin
                    dx = longint'($signed(q.ox)) - longint'($signed(q.px));
                    dy = longint'($signed(q.oy)) - longint'($signed(q.py));
                    if (dx == 0 && dy == 0) begin
                        res.degen = 1'b1;
                    end else begin
                        x = dx * 256;
                        y = dy * 256;
                        ang = 32'd0;
                        if (x < 0) begin
                            x = -x;
                            y = -y;
                            ang = 32'h80000000;
                        end
                        for (i = 0; i < ROT_STAGES; i++) begin
                            xs = x >>> i;
                            ys = y >>> i;
                            if (y >= 0) begin
                                x += ys; y -= xs; ang += ROT_ANGLE[i];
                            end else begin
                                x -= ys; y += xs; ang -= ROT_ANGLE[i];
                            end
                        end
                        r = scale_gain(x, 30 + GUARD);
                        res.radius = (r > 64'h7FFFFFFF) ? R_MAX : r[30:0];
                        rounded = {1'b0, ang} + 33'h8000;
                        res.bearing = rounded[31:16];
                    end
                end
                default: res = '0;
            endcase
            return res;
        endfunction

        function void note_request(conv_req_t q);
            awaited_results = {awaited_results, convert_arc(q)};
        endfunction

        function void flag_field(string name, longint unsigned want, longint unsigned got);
            if (bad_fields < PRINT_CAP)
                $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
            bad_fields++;
        endfunction

        function void check_result(logic [111:0] beat);
            conv_res_t want;
            conv_res_t got;
            got = conv_res_t'(beat);
            if (awaited_results.size() == 0) begin
                if (bad_fields < PRINT_CAP)
                    $display("%0t ns: unexpected result beat %0h", $time, beat);
                bad_fields++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.rx !== want.rx)
                flag_field("result_x", 64'(unsigned'(want.rx)), 64'(unsigned'(got.rx)));
            if (got.ry !== want.ry)
                flag_field("result_y", 64'(unsigned'(want.ry)), 64'(unsigned'(got.ry)));
            if (got.radius !== want.radius)
                flag_field("result_radius", 64'(want.radius), 64'(got.radius));
            if (got.bearing !== want.bearing)
                flag_field("result_bearing", 64'(want.bearing), 64'(got.bearing));
            if (got.degen !== want.degen)
                flag_field("degenerate", 64'(want.degen), 64'(got.degen));
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;

    arc_result_board board;
    int unsigned     cycle_count = 0;
    bit              tx_quiet = 1'b0;
    bit              rx_quiet = 1'b0;

    arc_center_end_polar_convert uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic conv_req_t mk(logic [1:0] op, logic signed [31:0] px,
                                     logic signed [31:0] py, logic signed [31:0] ox,
                                     logic signed [31:0] oy, logic [30:0] rad,
                                     logic [15:0] brg);
        conv_req_t q;
        q.op = op; q.px = px; q.py = py; q.ox = ox; q.oy = oy;
        q.radius = rad; q.bearing = brg;
        return q;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
            4: begin
                case ($urandom_range(0, 3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom_range(0, 32'h1FFFFFFF) - 32'h10000000;
        endcase
    endfunction

    task automatic send(input conv_req_t q);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, q};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(q);
    endtask

    // result side: random stall before each beat, then hold tready until one is taken
    initial begin
        int unsigned stall;
        repeat (RESET_CYCLES) @(posedge aclk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            board.check_result(m_tdata);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_arc_center_end_polar_convert: errors");
        $finish;
    end

    initial begin
        conv_req_t   q;
        int unsigned pick;
        int unsigned n;
        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send(mk(acep_pkg::OP_END, 0, 0, 0, 0, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_END, C_MAX, C_MAX, 0, 0, R_MAX, 16'h0000));
        send(mk(acep_pkg::OP_END, C_MIN, C_MIN, 0, 0, R_MAX, 16'h8000));
        send(mk(acep_pkg::OP_END, 0, 0, 0, 0, 31'(UNIT), 16'h4000));
        send(mk(acep_pkg::OP_END, 0, 0, 0, 0, 31'(UNIT), 16'hC000));
        send(mk(acep_pkg::OP_END, 0, 0, 0, 0, 31'(UNIT), 16'hFFFF));
        send(mk(acep_pkg::OP_END, -3 * UNIT, UNIT, 0, 0, 31'(UNIT), 16'h2000));
        send(mk(acep_pkg::OP_END, 0, C_MAX, 0, 0, R_MAX, 16'h6000));
        send(mk(acep_pkg::OP_CENTRE, UNIT, UNIT, 0, 0, 31'(UNIT), 16'h0000));
        send(mk(acep_pkg::OP_CENTRE, C_MIN, 0, 0, 0, R_MAX, 16'h0000));
        send(mk(acep_pkg::OP_CENTRE, 0, C_MAX, 0, 0, R_MAX, 16'hC000));
        send(mk(acep_pkg::OP_CENTRE, C_MAX, C_MIN, 0, 0, R_MAX, 16'hA000));
        send(mk(acep_pkg::OP_POLAR, 0, 0, 0, 0, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, C_MAX, C_MIN, C_MAX, C_MIN, R_MAX, 16'hFFFF));
        send(mk(acep_pkg::OP_POLAR, C_MIN, C_MIN, C_MAX, C_MAX, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, 0, 0, -UNIT, 0, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, 0, 0, 0, -UNIT, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, 0, 0, 0, 1, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, 0, 0, 1, 0, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, C_MAX, 0, C_MIN, -1, 31'd0, 16'h0000));
        send(mk(acep_pkg::OP_POLAR, 0, 0, UNIT, -1, 31'd0, 16'h0000));
        send(mk(OP_NONE, C_MAX, C_MAX, C_MAX, C_MAX, R_MAX, 16'hFFFF));
        send(mk(OP_NONE, 0, 0, 0, 0, 31'd0, 16'h0000));

        for (n = 0; n < RANDOM_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            q.op = (pick < 35) ? acep_pkg::OP_END : (pick < 70) ? acep_pkg::OP_CENTRE :
                   (pick < 95) ? acep_pkg::OP_POLAR : OP_NONE;
            q.px = rand_coord();
            q.py = rand_coord();
            q.ox = rand_coord();
            q.oy = rand_coord();
            case ($urandom_range(0, 3))
                0: q.radius = 31'($urandom);
                1: q.radius = 31'($urandom_range(0, 32'h00FFFFFF));
                2: q.radius = $urandom_range(0, 1) ? R_MAX : 31'd0;
                default: q.radius = 31'($urandom_range(0, 32'h7FFF));
            endcase
            q.bearing = 16'($urandom);
            if (q.op == acep_pkg::OP_POLAR) begin
                case ($urandom_range(0, 9))
                    0: begin
                        q.ox = q.px;
                        q.oy = q.py;
                    end
                    1, 2, 3, 4: begin
                        q.ox = q.px + ($urandom_range(0, 511) - 256);
                        q.oy = q.py + ($urandom_range(0, 511) - 256);
                    end
                    5: begin
                        if ($urandom_range(0, 1)) q.ox = q.px;
                        else q.oy = q.py;
                    end
                    default: ;
                endcase
            end
            send(q);
        end
        s_tvalid <= 1'b0;

        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.bad_fields == 0) begin
            $display("tb_arc_center_end_polar_convert: clean");
        end else begin
            $display("tb_arc_center_end_polar_convert: errors");
        end
        $finish;
    end

endmodule
